// ===== rtl/core/pqdc_pkg.sv =====
// Package for pair_qinv_delta_cut: widths, register indexes, sequencer states.
// No dependencies.
package pqdc_pkg;

    localparam int MOMENTUM_BITS_DEF = 22;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int ARITH_BITS        = 29;
    localparam int MASS_W            = 21;
    localparam int ABS_W             = 24;
    localparam int REL_W             = 19;
    localparam int Q_W               = 23;
    localparam int SQ_W              = 64;          // radicand width
    localparam int ROOT_W            = 32;
    localparam int DIV_W             = 39;          // |delta|*25600 fits
    localparam int PERCENT_SCALE     = 25600;
    localparam int ADDR_W            = 5;

    localparam logic [Q_W-1:0]   Q_MAX   = {Q_W{1'b1}};
    localparam logic [ABS_W-1:0] ABS_MAX = {1'b0, {(ABS_W-1){1'b1}}};
    localparam logic [ABS_W-1:0] ABS_MIN = {1'b1, {(ABS_W-1){1'b0}}};
    localparam logic [REL_W-1:0] REL_MAX = {1'b0, {(REL_W-1){1'b1}}};
    localparam logic [REL_W-1:0] REL_MIN = {1'b1, {(REL_W-1){1'b0}}};

    typedef enum logic [2:0] {
        REG_MASS_FIRST  = 3'd0,
        REG_MASS_SECOND = 3'd1,
        REG_ABS_LOW     = 3'd2,
        REG_ABS_HIGH    = 3'd3,
        REG_REL_LOW     = 3'd4,
        REG_REL_HIGH    = 3'd5
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUMS,
        ST_ROOT_A,
        ST_ROOT_B,
        ST_INNER,
        ST_ROOT_Q,
        ST_DELTA,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/core/pqdc_sqrt.sv =====
// Iterative floor square root, two radicand bits per cycle.
// Depends on pqdc_pkg.
module pqdc_sqrt (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [pqdc_pkg::SQ_W-1:0]       radicand,
    output logic                            done,
    output logic [pqdc_pkg::ROOT_W-1:0]     root
);
    import pqdc_pkg::*;

    logic [SQ_W-1:0]   rem_reg, rem_next;
    logic [SQ_W-1:0]   src_reg, src_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [SQ_W+1:0]   trial;
    logic [SQ_W+1:0]   shifted;

    always_comb begin
        shifted   = {rem_reg, src_reg[SQ_W-1 -: 2]};
        trial     = {{(SQ_W-ROOT_W){1'b0}}, root_reg, 2'b01};
        rem_next  = rem_reg;
        src_next  = src_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            src_next  = radicand;
            root_next = '0;
            cnt_next  = 6'(ROOT_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            src_next = {src_reg[SQ_W-3:0], 2'b00};
            if (shifted >= trial) begin
                rem_next  = SQ_W'(shifted - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = SQ_W'(shifted);
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == '0) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        src_reg  <= src_next;
        root_reg <= root_next;
    end

    assign done = busy_reg && (cnt_reg == '0);
    assign root = root_next;
endmodule

// ===== rtl/core/pqdc_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pqdc_pkg.
module pqdc_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [pqdc_pkg::DIV_W-1:0]   dividend,
    input  logic [pqdc_pkg::Q_W-1:0]     divisor,
    output logic                         done,
    output logic [pqdc_pkg::DIV_W-1:0]   quotient
);
    import pqdc_pkg::*;

    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [Q_W-1:0]   rem_reg, rem_next;
    logic [Q_W-1:0]   dsr_reg, dsr_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [Q_W:0]     part;

    always_comb begin
        part      = {rem_reg, quo_reg[DIV_W-1]};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = 6'(DIV_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (part >= {1'b0, dsr_reg}) begin
                rem_next = Q_W'(part - {1'b0, dsr_reg});
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = Q_W'(part);
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == '0) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = quo_next;
endmodule

// ===== rtl/core/pair_qinv_delta_cut.sv =====
// Top level of pair_qinv_delta_cut: registers, sequencer, result stage.
// Depends on pqdc_pkg, pqdc_sqrt, pqdc_div.
//
// Use: track pairs arrive on the s_ stream. tuser bit 0 is pair_kind
// (0 reconstructed, 1 truth), bit 1 truth_present. A reconstructed
// transaction computes q_inv and keeps it; it gives no output. A truth
// transaction with truth_present computes its own q_inv and gives one m_
// transaction with delta_abs, delta_rel, accept and zero_truth_q.
// Sequence: the momentum sums, three square roots on the shared root
// unit, the inner term, and for a truth pair the delta steps, a division
// unless its q_inv is zero, and the output step. s_tready returns once
// the third root of a reconstructed pair is done; a truth pair shows
// m_tvalid as the sequencer returns to idle, and the next pair can be
// taken then; a missing-truth pair skips the arithmetic for the output.
// s_tready is high only in idle; one pair is processed at a time.
// The result sits in an output register; a stalled receiver holds it and
// the next pair may still be accepted and processed meanwhile, but its
// result waits until the register is free.
// Reset: masses and windows return to their reset values, stored q to 0.
// Registers on APB at 4*index, written with psel&penable&pwrite.
module pair_qinv_delta_cut #(
    parameter int MOMENTUM_BITS = pqdc_pkg::MOMENTUM_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // first_px, first_py, first_pz, second_px, second_py, second_pz
    input  logic [((6*MOMENTUM_BITS+7)/8)*8-1:0] s_tdata,
    // pair_kind, truth_present
    input  logic [1:0]                s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // delta_abs, delta_rel, zero_truth_q (padded to bytes)
    output logic [47:0]               m_tdata,
    // accept
    output logic                      m_tuser,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [pqdc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import pqdc_pkg::*;

    localparam int EXCESS = (MOMENTUM_BITS > ARITH_BITS) ? MOMENTUM_BITS - ARITH_BITS : 0;
    localparam int AW = MOMENTUM_BITS - EXCESS;
    localparam logic [Q_W-1:0] Q_LIM = Q_W'(Q_MAX >> EXCESS);

    // configuration
    logic [MASS_W-1:0] mass1_reg, mass2_reg;
    logic signed [ABS_W-1:0] absl_reg, absh_reg;
    logic signed [REL_W-1:0] rell_reg, relh_reg;
    logic wr;
    reg_idx_t widx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign widx   = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mass1_reg <= MASS_W'(9110);
            mass2_reg <= MASS_W'(9110);
            absl_reg  <= ABS_MIN;
            absh_reg  <= ABS_MAX;
            rell_reg  <= REL_W'(-256000);
            relh_reg  <= REL_W'(256000);
        end else if (wr) begin
            unique case (widx)
                REG_MASS_FIRST:  mass1_reg <= pwdata[MASS_W-1:0];
                REG_MASS_SECOND: mass2_reg <= pwdata[MASS_W-1:0];
                REG_ABS_LOW:     absl_reg  <= pwdata[ABS_W-1:0];
                REG_ABS_HIGH:    absh_reg  <= pwdata[ABS_W-1:0];
                REG_REL_LOW:     rell_reg  <= pwdata[REL_W-1:0];
                REG_REL_HIGH:    relh_reg  <= pwdata[REL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            unique case (widx)
                REG_MASS_FIRST:  prdata = 32'(mass1_reg);
                REG_MASS_SECOND: prdata = 32'(mass2_reg);
                REG_ABS_LOW:     prdata = 32'($signed(absl_reg));
                REG_ABS_HIGH:    prdata = 32'($signed(absh_reg));
                REG_REL_LOW:     prdata = 32'($signed(rell_reg));
                REG_REL_HIGH:    prdata = 32'($signed(relh_reg));
                default:         prdata = '0;
            endcase
        end
    end

    // captured pair, shifted down when momenta are wider than the arithmetic
    logic signed [AW-1:0] a_reg [3];
    logic signed [AW-1:0] b_reg [3];
    logic                 kind_reg, present_reg;
    logic [1:0]           step_reg, step_next;
    logic [SQ_W-1:0]      sa_reg, sb_reg, dp_reg, acc_next_a, acc_next_b, acc_next_d;
    logic [ROOT_W-1:0]    ea_reg, eb_reg;
    logic [SQ_W-1:0]      inner_reg;
    logic [Q_W-1:0]       stored_q_reg, qt_reg;
    logic signed [ABS_W-1:0] delta_reg;
    logic [DIV_W-1:0]     mag_reg;

    state_t state_reg, state_next;

    // shared root unit and divider
    logic              sq_start, sq_done, dv_start, dv_done;
    logic [SQ_W-1:0]   sq_in;
    logic [ROOT_W-1:0] sq_root;
    logic [DIV_W-1:0]  dv_quo;

    pqdc_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start),
        .radicand(sq_in), .done(sq_done), .root(sq_root)
    );

    pqdc_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start),
        .dividend(mag_reg), .divisor(qt_reg), .done(dv_done), .quotient(dv_quo)
    );

    // output register
    logic                    ov_reg, ov_next;
    logic                    oacc_reg, ozero_reg;
    logic signed [ABS_W-1:0] oabs_reg;
    logic signed [REL_W-1:0] orel_reg;

    // one momentum component per cycle in the sum step
    logic signed [AW:0]       diff;
    logic signed [AW-1:0]     ca, cb;
    logic signed [2*AW-1:0]   pa, pb;
    logic signed [2*AW+1:0]   pd;
    logic [MASS_W-1:0]        m1s, m2s;
    logic [2*MASS_W-1:0]      msq1, msq2;
    always_comb begin
        ca   = a_reg[step_reg];
        cb   = b_reg[step_reg];
        m1s  = mass1_reg >> EXCESS;
        m2s  = mass2_reg >> EXCESS;
        msq1 = m1s * m1s;
        msq2 = m2s * m2s;
        diff = (AW+1)'(ca) - (AW+1)'(cb);
        pa   = ca * ca;
        pb   = cb * cb;
        pd   = diff * diff;
        acc_next_a = sa_reg + SQ_W'($unsigned(pa));
        acc_next_b = sb_reg + SQ_W'($unsigned(pb));
        acc_next_d = dp_reg + SQ_W'($unsigned(pd));
    end

    logic signed [ROOT_W:0]     e_diff;
    logic signed [2*ROOT_W+1:0] e_sq;
    logic signed [SQ_W:0]       inner_s;
    logic [Q_W-1:0]             q_sat;
    logic signed [Q_W+1:0]      dwide;
    logic [DIV_W-1:0]           dmag;
    logic [DIV_W-1:0]           quo_sat;
    logic signed [REL_W-1:0]    rel_val;
    logic                       out_free;

    always_comb begin
        e_diff  = {1'b0, ea_reg} - {1'b0, eb_reg};
        e_sq    = e_diff * e_diff;
        inner_s = (SQ_W+1)'(e_sq) - $signed({1'b0, dp_reg});
        q_sat   = (sq_root > ROOT_W'(Q_LIM)) ? Q_MAX : Q_W'(sq_root << EXCESS);
        dwide   = $signed({2'b0, stored_q_reg}) - $signed({2'b0, qt_reg});
        dmag    = DIV_W'(dwide[Q_W+1] ? -dwide : dwide);
        quo_sat = (dv_quo > DIV_W'(REL_MAX)) ? DIV_W'(REL_MAX) : dv_quo;
        rel_val = delta_reg[ABS_W-1] ? -$signed(REL_W'(quo_sat)) : $signed(REL_W'(quo_sat));
        if (delta_reg[ABS_W-1] && dv_quo > DIV_W'(REL_MAX)) rel_val = REL_MIN;
        out_free = !ov_reg || m_tready;
        ov_next  = ov_reg;
        if (m_tready) ov_next = 1'b0;
        if (state_reg == ST_OUT && out_free) ov_next = 1'b1;
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        sq_start   = 1'b0;
        sq_in      = sa_reg;
        dv_start   = 1'b0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                step_next = '0;
                if (s_tvalid)
                    state_next = (s_tuser[0] && !s_tuser[1]) ? ST_OUT : ST_SUMS;
            end
            ST_SUMS: begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd2) state_next = ST_ROOT_A;
            end
            ST_ROOT_A: begin
                sq_in = sa_reg;
                if (step_reg == 2'd3) begin
                    sq_start = 1'b1;
                    step_next = '0;
                end
                if (sq_done) begin
                    state_next = ST_ROOT_B;
                    step_next  = 2'd3;
                end
            end
            ST_ROOT_B: begin
                sq_in = sb_reg;
                if (step_reg == 2'd3) begin
                    sq_start = 1'b1;
                    step_next = '0;
                end
                if (sq_done) state_next = ST_INNER;
            end
            ST_INNER: begin
                state_next = ST_ROOT_Q;
                step_next  = 2'd3;
            end
            ST_ROOT_Q: begin
                sq_in = inner_reg;
                if (step_reg == 2'd3) begin
                    sq_start = 1'b1;
                    step_next = '0;
                end
                if (sq_done) state_next = kind_reg ? ST_DELTA : ST_IDLE;
            end
            ST_DELTA: begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd1) begin
                    if (qt_reg == '0) state_next = ST_OUT;
                    else begin
                        dv_start   = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (dv_done) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            stored_q_reg <= '0;
            ov_reg       <= 1'b0;
            step_reg     <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= (state_reg == ST_SUMS && step_reg == 2'd2) ? 2'd3 : step_next;
            if (state_reg == ST_ROOT_Q && sq_done && !kind_reg) stored_q_reg <= q_sat;
            ov_reg    <= ov_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            for (int i = 0; i < 3; i++) begin
                a_reg[i] <= AW'($signed(s_tdata[i*MOMENTUM_BITS +: MOMENTUM_BITS]) >>> EXCESS);
                b_reg[i] <= AW'($signed(s_tdata[(i+3)*MOMENTUM_BITS +: MOMENTUM_BITS]) >>> EXCESS);
            end
            kind_reg    <= s_tuser[0];
            present_reg <= s_tuser[1];
            sa_reg <= SQ_W'(msq1);
            sb_reg <= SQ_W'(msq2);
            dp_reg <= '0;
        end
        if (state_reg == ST_SUMS) begin
            sa_reg <= acc_next_a;
            sb_reg <= acc_next_b;
            dp_reg <= acc_next_d;
        end
        if (state_reg == ST_ROOT_A && sq_done) ea_reg <= sq_root;
        if (state_reg == ST_ROOT_B && sq_done) eb_reg <= sq_root;
        if (state_reg == ST_INNER)
            inner_reg <= inner_s[SQ_W] ? SQ_W'(-inner_s) : SQ_W'(inner_s);
        if (state_reg == ST_ROOT_Q && sq_done) qt_reg <= q_sat;
        if (state_reg == ST_DELTA && step_reg == 2'd0) begin
            if (dwide > $signed((Q_W+2)'(ABS_MAX)))      delta_reg <= ABS_MAX;
            else if (dwide < $signed(-(Q_W+2)'(8388608))) delta_reg <= ABS_MIN;
            else                                          delta_reg <= ABS_W'(dwide);
        end
        // |delta| * 25600 as 16384 + 8192 + 1024
        if (state_reg == ST_DELTA && step_reg == 2'd0) begin
            mag_reg <= (dmag << 14) + (dmag << 13) + (dmag << 10);
        end
        if (state_reg == ST_OUT && out_free) begin
            if (kind_reg && !present_reg) begin
                oacc_reg  <= 1'b0;
                oabs_reg  <= ABS_MAX;
                orel_reg  <= REL_MAX;
                ozero_reg <= 1'b0;
            end else begin
                oabs_reg  <= delta_reg;
                orel_reg  <= (qt_reg == '0) ? REL_MAX : rel_val;
                ozero_reg <= (qt_reg == '0);
                oacc_reg  <= (delta_reg >= absl_reg) && (delta_reg <= absh_reg) &&
                             (((qt_reg == '0) ? $signed(REL_MAX) : rel_val) >= rell_reg) &&
                             (((qt_reg == '0) ? $signed(REL_MAX) : rel_val) <= relh_reg);
            end
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tuser  = oacc_reg;
    assign m_tdata  = {4'b0, ozero_reg, orel_reg, oabs_reg};
endmodule

// ===== rtl/core/pqdc_checker.sv =====
// Port-level checker for pair_qinv_delta_cut, bound to the top level.
// Depends on pqdc_pkg.
module pqdc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        pready
);
    import pqdc_pkg::*;

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready right after accept");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[47:44] == 4'b0)
        else $error("padding not zero");
endmodule

bind pair_qinv_delta_cut pqdc_checker u_pqdc_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .pready(pready)
);
